>>> rtl/core/bcbq_pkg.sv
// Shared types and constants for the chained byte queue block
package bcbq_pkg;
	localparam int NUM_BLOCKS_DEF  = 64;
	localparam int BLOCK_BYTES_DEF = 32;
	localparam int NUM_QUEUES_DEF  = 4;

	localparam int CMD_W = 3;
	localparam int QSEL_W = 2;
	localparam int BYTE_W = 8;
	localparam int CNT_W = 12;
	localparam int STAT_W = 2;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND = 3'd0,
		CMD_POP_HEAD = 3'd1,
		CMD_POP_TAIL = 3'd2,
		CMD_DISCARD = 3'd3,
		CMD_COUNT = 3'd4
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK = 2'd0,
		ST_EMPTY = 2'd1,
		ST_NOFREE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_APP_LINK,
		S_HEAD_RD,
		S_HEAD_WAIT,
		S_HEAD_DO,
		S_TAIL_WAIT,
		S_TAIL_DO,
		S_WALK_WAIT,
		S_WALK_DO,
		S_CNT_WAIT,
		S_CNT_DO,
		S_DONE
	} state_t;
endpackage

>>> rtl/core/block_chained_byte_queues.sv
// Top level of the chained byte queue block: sequencer, queue registers and memories
//
// channel | direction | handshake     | payload
// in      | input     | in_valid/in_stall   | command, queue_sel, data_byte, amount, flag_mask
// out     | output    | out_valid/out_stall | status, read_byte, counted, queue_length
//
// One beat at a time. Append passes S_DECODE, then S_APP_LINK when it needs a new
// block, then S_DONE; remove head passes S_HEAD_RD, S_HEAD_WAIT and S_HEAD_DO;
// remove last walks the chain block by block; discard repeats the head read per byte;
// count scans byte by byte. The registered reads of the byte and link memories set the rate.
// Reset clears queue registers; the link memory is chained by a sweep after reset,
// during which no beat is taken. A waiting result holds in the
// output register while out_stall is high.
module block_chained_byte_queues
	import bcbq_pkg::*;
#(
	parameter int NUM_BLOCKS  = NUM_BLOCKS_DEF,
	parameter int BLOCK_BYTES = BLOCK_BYTES_DEF,
	parameter int NUM_QUEUES  = NUM_QUEUES_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [CMD_W-1:0]  command,
	input  logic [QSEL_W-1:0] queue_sel,
	input  logic [BYTE_W-1:0] data_byte,
	input  logic [CNT_W-1:0]  amount,
	input  logic [BYTE_W-1:0] flag_mask,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [STAT_W-1:0] status,
	output logic [BYTE_W-1:0] read_byte,
	output logic [CNT_W-1:0]  counted,
	output logic [CNT_W-1:0]  queue_length
);
	localparam int BW  = $clog2(NUM_BLOCKS);
	localparam int LW  = $clog2(NUM_BLOCKS + 1);
	localparam int OW  = $clog2(BLOCK_BYTES);
	localparam int AW  = BW + OW;
	localparam int QW  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
	localparam logic [LW-1:0] NIL = LW'(NUM_BLOCKS);
	localparam logic [OW-1:0] OFF_LAST = OW'(BLOCK_BYTES - 1);

	logic [BYTE_W-1:0] byte_mem [NUM_BLOCKS*BLOCK_BYTES];
	logic [LW-1:0]     link_mem [NUM_BLOCKS];

	logic [AW-1:0]   head_q [NUM_QUEUES];
	logic [AW-1:0]   tail_q [NUM_QUEUES];
	logic [CNT_W-1:0] count_q [NUM_QUEUES];
	logic [LW-1:0]   free_q;

	state_t state_q, state_d;
	logic [BW:0]     sweep_q;
	logic            sweeping;

	logic [CMD_W-1:0]  cmd_q;
	logic [QW-1:0]     q_q;
	logic              qbad_q;
	logic [BYTE_W-1:0] data_q, mask_q;
	logic [CNT_W-1:0]  amt_q, cnt_q, n_q;
	logic [BW-1:0]     walk_q;
	logic [BW-1:0]     newblk_q;

	logic [BYTE_W-1:0] st_q, rd_q;
	logic [CNT_W-1:0]  ct_q, ql_q;
	logic              ov_q;

	// memory ports
	logic              bwe, lre, lwe, bre;
	logic [AW-1:0]     baddr;
	logic [BYTE_W-1:0] bwdata, brdata;
	logic [BW-1:0]     lwaddr, lraddr;
	logic [LW-1:0]     lwdata, lrdata;

	always_ff @(posedge clk) begin
		if (bwe)
			byte_mem[baddr] <= bwdata;
		if (bre)
			brdata <= byte_mem[baddr];
	end

	always_ff @(posedge clk) begin
		if (lwe)
			link_mem[lwaddr] <= lwdata;
		if (lre)
			lrdata <= link_mem[lraddr];
	end

	logic [CNT_W-1:0] cur_cnt;
	logic [AW-1:0]    cur_head, cur_tail;
	logic [BW-1:0]    head_blk, tail_blk;
	logic             q_ok;

	assign q_ok = (NUM_QUEUES >= (1 << QSEL_W)) || (32'(queue_sel) < NUM_QUEUES);
	assign cur_cnt = count_q[q_q];
	assign cur_head = head_q[q_q];
	assign cur_tail = tail_q[q_q];
	assign head_blk = cur_head[AW-1:OW];
	assign tail_blk = cur_tail[AW-1:OW];

	assign sweeping = !sweep_q[BW];
	assign in_stall = sweeping || (state_q != S_IDLE) || ov_q;
	assign out_valid = ov_q;
	assign status = st_q[STAT_W-1:0];
	assign read_byte = rd_q;
	assign counted = ct_q;
	assign queue_length = ql_q;

	logic [OW-1:0] head_off, tail_off;
	assign head_off = cur_head[OW-1:0];
	assign tail_off = cur_tail[OW-1:0];
	logic [CNT_W-1:0] room;
	assign room = CNT_W'(BLOCK_BYTES) - CNT_W'(head_off);

	// combinational sequencer
	always_comb begin
		state_d = state_q;
		bwe = 1'b0; bre = 1'b0; lwe = 1'b0; lre = 1'b0;
		baddr = cur_head; bwdata = data_q;
		lwaddr = free_q[BW-1:0]; lwdata = NIL; lraddr = free_q[BW-1:0];
		if (sweeping) begin
			lwe = 1'b1;
			lwaddr = sweep_q[BW-1:0];
			lwdata = LW'(sweep_q) + LW'(1);
		end
		case (state_q)
			S_IDLE: if (in_valid && !in_stall)
				state_d = q_ok ? S_DECODE : S_DONE;
			S_DECODE: begin
				if (cmd_q == CMD_APPEND) begin
					if (cur_cnt != '0 && tail_off != OFF_LAST) begin
						bwe = 1'b1; baddr = cur_tail + AW'(1);
						state_d = S_DONE;
					end else if (free_q == NIL) begin
						state_d = S_DONE;
					end else begin
						lre = 1'b1; lraddr = free_q[BW-1:0];
						state_d = S_APP_LINK;
					end
				end else if (cmd_q > CMD_COUNT || cur_cnt == '0) begin
					state_d = S_DONE;
				end else if (cmd_q == CMD_POP_TAIL) begin
					bre = 1'b1; baddr = cur_tail;
					lre = 1'b1; lraddr = head_blk;
					state_d = S_TAIL_WAIT;
				end else if (cmd_q == CMD_COUNT) begin
					bre = 1'b1; baddr = cur_head;
					state_d = S_CNT_WAIT;
				end else begin
					state_d = S_HEAD_RD;
				end
			end
			S_APP_LINK: begin
				// new block now taken; write byte, link old tail to it, or end the chain at it if the queue was empty
				bwe = 1'b1; baddr = {newblk_q, {OW{1'b0}}};
				lwe = 1'b1;
				if (cur_cnt != '0) begin
					lwaddr = tail_blk; lwdata = LW'(newblk_q);
				end else begin
					lwaddr = newblk_q; lwdata = NIL;
				end
				state_d = S_DONE;
			end
			S_HEAD_RD: begin
				if (cmd_q == CMD_DISCARD && (cnt_q == amt_q || cur_cnt == '0)) begin
					state_d = S_DONE;
				end else begin
					bre = 1'b1; baddr = cur_head;
					lre = 1'b1; lraddr = head_blk;
					state_d = S_HEAD_WAIT;
				end
			end
			S_HEAD_WAIT: state_d = S_HEAD_DO;
			S_HEAD_DO: begin
				if (cur_cnt == CNT_W'(1) || head_off == OFF_LAST) begin
					lwe = 1'b1; lwaddr = head_blk; lwdata = free_q;
				end
				state_d = (cmd_q == CMD_DISCARD) ? S_HEAD_RD : S_DONE;
			end
			S_TAIL_WAIT: state_d = S_TAIL_DO;
			S_TAIL_DO: begin
				if (cur_cnt == CNT_W'(1) || tail_off != '0) begin
					if (cur_cnt == CNT_W'(1)) begin
						lwe = 1'b1; lwaddr = tail_blk; lwdata = free_q;
					end
					state_d = S_DONE;
				end else begin
					state_d = S_WALK_DO;
				end
			end
			S_WALK_WAIT: state_d = S_WALK_DO;
			S_WALK_DO: begin
				if (lrdata == LW'(tail_blk) || n_q == CNT_W'(NUM_BLOCKS)) begin
					lwe = 1'b1; lwaddr = walk_q; lwdata = NIL;
					state_d = S_DONE;
				end else begin
					lre = 1'b1;
					lraddr = (lrdata < NIL) ? lrdata[BW-1:0] : '0;
					state_d = S_WALK_WAIT;
				end
			end
			S_CNT_WAIT: state_d = S_CNT_DO;
			S_CNT_DO: begin
				if (cnt_q == n_q || (brdata & mask_q) != '0) begin
					state_d = S_DONE;
				end else begin
					bre = 1'b1; baddr = cur_head + AW'(cnt_q) + AW'(1);
					state_d = (cnt_q + CNT_W'(1) == n_q) ? S_CNT_DO : S_CNT_WAIT;
				end
			end
			S_DONE: if (!ov_q) begin
				// remove-last that unlinked a block returns it to the free list
				if (cmd_q == CMD_POP_TAIL && n_q != '0) begin
					lwe = 1'b1; lwaddr = newblk_q; lwdata = free_q;
				end
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sweep_q <= '0;
			free_q <= '0;
			ov_q <= 1'b0;
			for (int i = 0; i < NUM_QUEUES; i++) begin
				head_q[i] <= '0; tail_q[i] <= '0; count_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (sweeping)
				sweep_q <= sweep_q + (BW+1)'(1);
			if (ov_q && !out_stall)
				ov_q <= 1'b0;
			case (state_q)
				S_DECODE: if (cmd_q == CMD_APPEND) begin
					if (cur_cnt != '0 && tail_off != OFF_LAST) begin
						tail_q[q_q] <= cur_tail + AW'(1);
						count_q[q_q] <= cur_cnt + CNT_W'(1);
					end
				end
				S_APP_LINK: begin
					free_q <= lrdata;
					tail_q[q_q] <= {newblk_q, {OW{1'b0}}};
					if (cur_cnt == '0)
						head_q[q_q] <= {newblk_q, {OW{1'b0}}};
					count_q[q_q] <= cur_cnt + CNT_W'(1);
				end
				S_HEAD_DO: begin
					count_q[q_q] <= cur_cnt - CNT_W'(1);
					if (cur_cnt == CNT_W'(1)) begin
						free_q <= LW'(head_blk);
						head_q[q_q] <= '0; tail_q[q_q] <= '0;
					end else if (head_off == OFF_LAST) begin
						free_q <= LW'(head_blk);
						head_q[q_q] <= {(lrdata < NIL) ? lrdata[BW-1:0] : BW'(0),
							{OW{1'b0}}};
					end else begin
						head_q[q_q] <= cur_head + AW'(1);
					end
				end
				S_TAIL_DO: begin
					if (cur_cnt == CNT_W'(1)) begin
						count_q[q_q] <= '0;
						free_q <= LW'(tail_blk);
						head_q[q_q] <= '0; tail_q[q_q] <= '0;
					end else if (tail_off != '0) begin
						count_q[q_q] <= cur_cnt - CNT_W'(1);
						tail_q[q_q] <= cur_tail - AW'(1);
					end
				end
				S_WALK_DO: if (lrdata == LW'(tail_blk) || n_q == CNT_W'(NUM_BLOCKS)) begin
					count_q[q_q] <= cur_cnt - CNT_W'(1);
					tail_q[q_q] <= {walk_q, OFF_LAST};
				end
				default: ;
			endcase
			// final link update of remove-last frees the old tail block
			if (state_q == S_DONE && cmd_q == CMD_POP_TAIL && n_q != '0)
				free_q <= LW'(newblk_q);
			if (state_q == S_DONE && !ov_q)
				ov_q <= 1'b1;
		end
	end

	// payload and working registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid && !in_stall) begin
			cmd_q <= command; q_q <= QW'(queue_sel); qbad_q <= !q_ok;
			data_q <= data_byte; amt_q <= amount; mask_q <= flag_mask;
			cnt_q <= '0; n_q <= '0;
			st_q <= q_ok ? BYTE_W'(ST_OK) : BYTE_W'(ST_EMPTY);
			rd_q <= '0; ct_q <= '0; ql_q <= '0;
		end
		case (state_q)
			S_DECODE: begin
				if (cmd_q == CMD_APPEND) begin
					if (!(cur_cnt != '0 && tail_off != OFF_LAST) && free_q == NIL)
						st_q <= BYTE_W'(ST_NOFREE);
					newblk_q <= free_q[BW-1:0];
				end else if (cmd_q <= CMD_COUNT && cur_cnt == '0) begin
					st_q <= BYTE_W'(ST_EMPTY);
				end
				walk_q <= head_blk;
				n_q <= (cmd_q == CMD_COUNT) ? ((room < cur_cnt) ? room : cur_cnt) : '0;
			end
			S_HEAD_DO: begin
				rd_q <= brdata;
				cnt_q <= cnt_q + CNT_W'(1);
			end
			S_TAIL_DO: begin
				rd_q <= brdata;
				newblk_q <= tail_blk;
				n_q <= (cur_cnt != CNT_W'(1) && tail_off == '0) ? CNT_W'(1) : '0;
			end
			S_WALK_DO: begin
				if (!(lrdata == LW'(tail_blk) || n_q == CNT_W'(NUM_BLOCKS))) begin
					walk_q <= (lrdata < NIL) ? lrdata[BW-1:0] : '0;
					n_q <= n_q + CNT_W'(1);
				end
			end
			S_CNT_DO: begin
				if (mask_q == '0)
					cnt_q <= n_q;
				else if (!(cnt_q == n_q || (brdata & mask_q) != '0))
					cnt_q <= cnt_q + CNT_W'(1);
			end
			S_DONE: if (!ov_q) begin
				if (cmd_q == CMD_DISCARD || cmd_q == CMD_COUNT)
					ct_q <= cnt_q;
				if (cmd_q != CMD_POP_HEAD && cmd_q != CMD_POP_TAIL)
					rd_q <= '0;
				ql_q <= qbad_q ? '0 : cur_cnt;
				if (st_q == BYTE_W'(ST_EMPTY) || st_q == BYTE_W'(ST_NOFREE))
					ct_q <= '0;
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != S_IDLE) |-> in_stall)
		else $error("beat taken while busy");
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> $past(state_q) == S_DONE)
		else $error("result without completion");
	assert property (@(posedge clk) disable iff (!arst_n)
		sweeping |-> state_q == S_IDLE)
		else $error("work during link sweep");
endmodule
